@@ rtl/core/tpz_pkg.sv @@
// Shared constants for the two-proportion z statistic pipeline.
`default_nettype none
package tpz_pkg;
	// default configuration
	localparam int CNT_BITS_DEF  = 16;
	localparam int FRAC_BITS_DEF = 16;

	// fixed field widths
	localparam int DELTA_W = 18;
	localparam int EST_W   = 18;
	localparam int Z_W     = 24;
	localparam int SE_W    = 17;

	// extra fraction bits of the z denominator, and the matching pre-shift of its radicand
	localparam int GUARD    = 8;
	localparam int SQ_SHIFT = 16;

	// z saturation limits
	localparam int Z_MAX     = 8388607;
	localparam int Z_MIN_MAG = 8388608;
endpackage
`default_nettype wire

@@ rtl/core/tpz_in_if.sv @@
// Input channel: two success counts and two sample sizes per transaction.
`default_nettype none
interface tpz_in_if #(parameter int COUNT_BITS = 16);
	logic                  valid;
	logic                  ready;
	logic [COUNT_BITS-1:0] succ_a;
	logic [COUNT_BITS-1:0] size_a;
	logic [COUNT_BITS-1:0] succ_b;
	logic [COUNT_BITS-1:0] size_b;

	modport source (output valid, succ_a, size_a, succ_b, size_b, input ready);
	modport sink (input valid, succ_a, size_a, succ_b, size_b, output ready);
endinterface
`default_nettype wire

@@ rtl/core/tpz_out_if.sv @@
// Result channel: estimate, z statistic, standard error and validity flag.
`default_nettype none
interface tpz_out_if
	import tpz_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic signed [EST_W-1:0]   estimate;
	logic signed [Z_W-1:0]     z_score;
	logic        [SE_W-1:0]    std_error;
	logic                      inputs_valid;

	modport source (output valid, estimate, z_score, std_error, inputs_valid, input ready);
	modport sink (input valid, estimate, z_score, std_error, inputs_valid, output ready);
endinterface
`default_nettype wire

@@ rtl/core/tpz_cfg_if.sv @@
// Configuration write channel carrying the hypothesised difference.
`default_nettype none
interface tpz_cfg_if
	import tpz_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic signed [DELTA_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/two_proportion_z_statistic.sv @@
// Top level: pooled two-proportion z statistic, fully pipelined.
//
//  channel  modport  direction  carries
//  samples  sink     in         succ_a, size_a, succ_b, size_b
//  result   source   out        estimate, z_score, std_error, inputs_valid
//  cfg      sink     in         data (hypothesised difference delta_p0)
//
// One transaction enters per cycle while the pipeline is not stalled. Between the
// registered stages sit the four bit-per-stage units (proportion divider, variance
// divider, square root, z divider). No state: reset only clears valid bits and
// sets delta_p0 to zero. The whole pipeline holds while a result waits untaken;
// samples.ready is low only then.
`default_nettype none
module two_proportion_z_statistic
	import tpz_pkg::*;
#(
	parameter int COUNT_BITS = CNT_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	tpz_in_if.sink      samples,
	tpz_out_if.source   result,
	tpz_cfg_if.sink     cfg
);
	localparam int C    = COUNT_BITS;
	localparam int F    = FRAC_BITS;
	localparam int RNW  = C + F + 2;
	localparam int RDW  = C + 1;
	localparam int PW   = F + 1;
	localparam int MW   = 2 * F + 2;
	localparam int SQW  = MW + SQ_SHIFT;
	localparam int RTW  = SQW / 2;
	localparam int SEW  = RTW - GUARD;
	localparam int EW   = F + 2;
	localparam int NMW  = ((EW > DELTA_W) ? EW : DELTA_W) + 1;
	localparam int ZNW  = NMW + F + GUARD;

	localparam logic [RNW-1:0] PQ_HI      = RNW'((1 << F) - 1);
	localparam logic [PW-1:0]  ONE_P      = PW'(1 << F);
	localparam logic [Z_W-1:0] Z_SAT_MAG  = Z_W'(Z_MIN_MAG);
	localparam logic [Z_W-1:0] Z_SAT_POS  = Z_W'(Z_MAX);
	localparam logic [ZNW-1:0] Z_SAT_WIDE = ZNW'(Z_MIN_MAG);

	logic en;

	// configuration register
	logic signed [DELTA_W-1:0] delta_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delta_q <= '0;
		end else if (cfg.valid) begin
			delta_q <= cfg.data;
		end
	end

	// stage 1: capture the transaction
	logic         valid_s1;
	logic [C-1:0] x1_s1, n1_s1, x2_s1, n2_s1;

	assign samples.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s1 <= samples.succ_a;
			n1_s1 <= samples.size_a;
			x2_s1 <= samples.succ_b;
			n2_s1 <= samples.size_b;
		end
	end

	// stage 2: validity check and rounded proportion dividends
	logic                      valid_s2, ok_s2;
	logic [2:0][RNW-1:0]       num_s2;
	logic [2:0][RDW-1:0]       den_s2;
	logic [C-1:0]              n1_s2, n2_s2;
	logic [C:0]                xs, ns;

	assign xs = (C+1)'(x1_s1) + (C+1)'(x2_s1);
	assign ns = (C+1)'(n1_s1) + (C+1)'(n2_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s2     <= (x1_s1 < n1_s1) && (x2_s1 < n2_s1) &&
			             !((x1_s1 == '0) && (x2_s1 == '0));
			num_s2[0] <= RNW'({x1_s1, {F{1'b0}}}) + RNW'(n1_s1 >> 1);
			num_s2[1] <= RNW'({x2_s1, {F{1'b0}}}) + RNW'(n2_s1 >> 1);
			num_s2[2] <= RNW'({xs, {F{1'b0}}}) + RNW'(ns >> 1);
			den_s2[0] <= RDW'(n1_s1);
			den_s2[1] <= RDW'(n2_s1);
			den_s2[2] <= ns;
			n1_s2     <= n1_s1;
			n2_s2     <= n2_s1;
		end
	end

	// proportion divider: p1, p2 and pooled
	logic                  prop_valid;
	logic [2:0][RNW-1:0]   prop_q;
	logic [2*C:0]          prop_side;

	tpz_div #(.LANES(3), .NW(RNW), .DW(RDW), .SIDE_W(2*C+1)) u_prop_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(valid_s2), .num(num_s2), .den(den_s2),
		.side_in({ok_s2, n1_s2, n2_s2}),
		.out_valid(prop_valid), .quo(prop_q), .side_out(prop_side)
	);

	// stage 3: clamp the pooled proportion, form the estimate
	logic                 valid_s3, ok_s3;
	logic [PW-1:0]        p1_s3, p2_s3, pq_s3;
	logic signed [EW-1:0] est_s3;
	logic [C-1:0]         n1_s3, n2_s3;
	logic [RNW-1:0]       pq_cl;

	always_comb begin
		pq_cl = prop_q[2];
		if (pq_cl == '0) begin
			pq_cl = RNW'(1);
		end else if (pq_cl > PQ_HI) begin
			pq_cl = PQ_HI;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= prop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s3  <= prop_side[2*C];
			n1_s3  <= prop_side[2*C-1:C];
			n2_s3  <= prop_side[C-1:0];
			p1_s3  <= prop_q[0][PW-1:0];
			p2_s3  <= prop_q[1][PW-1:0];
			pq_s3  <= pq_cl[PW-1:0];
			est_s3 <= $signed({1'b0, prop_q[0][PW-1:0]}) - $signed({1'b0, prop_q[1][PW-1:0]});
		end
	end

	// stage 4: variance products p*(1-p)
	logic                 valid_s4, ok_s4;
	logic [3:0][MW-1:0]   prod_s4;
	logic [3:0][C-1:0]    den_s4;
	logic signed [EW-1:0] est_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s4      <= ok_s3;
			est_s4     <= est_s3;
			prod_s4[0] <= MW'(p1_s3) * MW'(PW'(ONE_P - p1_s3));
			prod_s4[1] <= MW'(p2_s3) * MW'(PW'(ONE_P - p2_s3));
			prod_s4[2] <= MW'(pq_s3) * MW'(PW'(ONE_P - pq_s3));
			prod_s4[3] <= MW'(pq_s3) * MW'(PW'(ONE_P - pq_s3));
			den_s4[0]  <= n1_s3;
			den_s4[1]  <= n2_s3;
			den_s4[2]  <= n1_s3;
			den_s4[3]  <= n2_s3;
		end
	end

	// variance divider: unpooled and pooled terms
	logic                var_valid;
	logic [3:0][MW-1:0]  var_q;
	logic [EW:0]         var_side;

	tpz_div #(.LANES(4), .NW(MW), .DW(C), .SIDE_W(EW+1)) u_var_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(valid_s4), .num(prod_s4), .den(den_s4),
		.side_in({ok_s4, est_s4}),
		.out_valid(var_valid), .quo(var_q), .side_out(var_side)
	);

	// stage 5: sum the terms, pre-shift both radicands alike
	logic                valid_s5;
	logic [1:0][SQW-1:0] rad_s5;
	logic [EW:0]         side_s5;
	logic [MW-1:0]       v_sum, w_sum;

	assign v_sum = var_q[0] + var_q[1];
	assign w_sum = var_q[2] + var_q[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= var_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s5[0] <= {v_sum, {SQ_SHIFT{1'b0}}};
			rad_s5[1] <= {w_sum, {SQ_SHIFT{1'b0}}};
			side_s5   <= var_side;
		end
	end

	// square roots: standard error and z denominator
	logic                sq_valid;
	logic [1:0][RTW-1:0] sq_root;
	logic [EW:0]         sq_side;

	tpz_sqrt #(.LANES(2), .VW(SQW), .SIDE_W(EW+1)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(valid_s5), .radicand(rad_s5), .side_in(side_s5),
		.out_valid(sq_valid), .root(sq_root), .side_out(sq_side)
	);

	// stage 6: numerator against the hypothesised difference
	logic                  valid_s6, ok_s6;
	logic [SEW-1:0]        se_s6;
	logic [RTW-1:0]        d_s6;
	logic signed [EW-1:0]  est_s6;
	logic signed [NMW-1:0] num_s6;
	logic signed [EW-1:0]  sq_est;

	assign sq_est = $signed(sq_side[EW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s6 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s6  <= sq_side[EW];
			est_s6 <= sq_est;
			se_s6  <= sq_root[0][RTW-1:GUARD];
			d_s6   <= sq_root[1];
			num_s6 <= NMW'(sq_est) - NMW'(delta_q);
		end
	end

	// stage 7: magnitude, flags and rounded z dividend
	logic                 valid_s7, ok_s7, neg_s7, magz_s7, dz_s7;
	logic [0:0][ZNW-1:0]  znum_s7;
	logic [0:0][RTW-1:0]  zden_s7;
	logic signed [EW-1:0] est_s7;
	logic [SEW-1:0]       se_s7;
	logic [NMW-1:0]       mag;

	assign mag = num_s6[NMW-1] ? NMW'(-num_s6) : NMW'(num_s6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s7      <= ok_s6;
			neg_s7     <= num_s6[NMW-1];
			magz_s7    <= num_s6 == '0;
			dz_s7      <= d_s6 == '0;
			est_s7     <= est_s6;
			se_s7      <= se_s6;
			znum_s7[0] <= {mag, {(F+GUARD){1'b0}}} + ZNW'(d_s6 >> 1);
			zden_s7[0] <= d_s6;
		end
	end

	// z divider
	localparam int ZSIDE_W = 4 + EW + SEW;

	logic                z_valid;
	logic [0:0][ZNW-1:0] z_q;
	logic [ZSIDE_W-1:0]  z_side;

	tpz_div #(.LANES(1), .NW(ZNW), .DW(RTW), .SIDE_W(ZSIDE_W)) u_z_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(valid_s7), .num(znum_s7), .den(zden_s7),
		.side_in({ok_s7, neg_s7, magz_s7, dz_s7, est_s7, se_s7}),
		.out_valid(z_valid), .quo(z_q), .side_out(z_side)
	);

	// stage 8: saturate, sign and zero invalid results
	logic                   valid_s8, ok_s8;
	logic signed [EST_W-1:0] est_s8;
	logic signed [Z_W-1:0]  z_s8;
	logic [SE_W-1:0]        se_s8;
	logic                   f_ok, f_neg, f_magz, f_dz;
	logic signed [EW-1:0]   f_est;
	logic [SEW-1:0]         f_se;
	logic [Z_W-1:0]         zmag;

	assign {f_ok, f_neg, f_magz, f_dz, f_est, f_se} = z_side;

	always_comb begin
		priority if (f_magz) begin
			zmag = '0;
		end else if (f_dz || (z_q[0] > Z_SAT_WIDE)) begin
			zmag = Z_SAT_MAG;
		end else begin
			zmag = z_q[0][Z_W-1:0];
		end
		if (!f_neg && (zmag > Z_SAT_POS)) begin
			zmag = Z_SAT_POS;
		end
	end

	assign en = !valid_s8 || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
		end else if (en) begin
			valid_s8 <= z_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s8  <= f_ok;
			est_s8 <= f_ok ? EST_W'(f_est) : '0;
			se_s8  <= f_ok ? SE_W'(f_se) : '0;
			z_s8   <= !f_ok ? '0 : (f_neg ? $signed(Z_W'(-zmag)) : $signed(zmag));
		end
	end

	assign result.valid        = valid_s8;
	assign result.estimate     = est_s8;
	assign result.z_score      = z_s8;
	assign result.std_error    = se_s8;
	assign result.inputs_valid = ok_s8;

	// invalid inputs give all-zero numeric fields
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.inputs_valid) |->
		(result.estimate == '0 && result.z_score == '0 && result.std_error == '0))
		else $error("invalid transaction produced nonzero fields");

	// a valid proportion pair bounds the standard error by one
	a_se_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.inputs_valid) |->
		(SE_W'(result.std_error) <= SE_W'(1 << F)))
		else $error("standard error above one");

	// a held result stalls the whole pipeline and the input
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready) |=> $stable(z_s8) && $stable(valid_s7))
		else $error("pipeline moved during a stall");
endmodule
`default_nettype wire

@@ rtl/core/tpz_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, several lanes sharing a valid.
`default_nettype none
module tpz_div #(
	parameter int LANES  = 1,
	parameter int NW     = 8,
	parameter int DW     = 4,
	parameter int SIDE_W = 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [LANES-1:0][NW-1:0]     num,
	input  logic [LANES-1:0][DW-1:0]     den,
	input  logic [SIDE_W-1:0]            side_in,
	output logic                         out_valid,
	output logic [LANES-1:0][NW-1:0]     quo,
	output logic [SIDE_W-1:0]            side_out
);
	logic                      valid_s [0:NW];
	logic [LANES-1:0][DW-1:0]  rem_s   [0:NW];
	logic [LANES-1:0][NW-1:0]  dvd_s   [0:NW];
	logic [LANES-1:0][DW-1:0]  dsr_s   [0:NW];
	logic [LANES-1:0][NW-1:0]  quo_s   [0:NW];
	logic [SIDE_W-1:0]         side_s  [0:NW];

	// feed the first stage
	assign valid_s[0] = in_valid;
	assign rem_s[0]   = '0;
	assign dvd_s[0]   = num;
	assign dsr_s[0]   = den;
	assign quo_s[0]   = '0;
	assign side_s[0]  = side_in;

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [LANES-1:0][DW:0]   trial;
		logic [LANES-1:0]         take;
		logic [LANES-1:0][DW-1:0] rem_nx;

		// bring down the next dividend bit, subtract the divisor when it fits
		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				trial[l]  = {rem_s[k][l], dvd_s[k][l][NW-1]};
				take[l]   = trial[l] >= {1'b0, dsr_s[k][l]};
				rem_nx[l] = take[l] ? DW'(trial[l] - {1'b0, dsr_s[k][l]}) : trial[l][DW-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (en) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		// advance payload
		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < LANES; l++) begin
					rem_s[k+1][l] <= rem_nx[l];
					dvd_s[k+1][l] <= {dvd_s[k][l][NW-2:0], 1'b0};
					dsr_s[k+1][l] <= dsr_s[k][l];
					quo_s[k+1][l] <= {quo_s[k][l][NW-2:0], take[l]};
				end
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = valid_s[NW];
	assign quo       = quo_s[NW];
	assign side_out  = side_s[NW];
endmodule
`default_nettype wire

@@ rtl/core/tpz_sqrt.sv @@
// Pipelined restoring integer square root, one root bit per stage, several lanes.
`default_nettype none
module tpz_sqrt #(
	parameter int LANES  = 1,
	parameter int VW     = 8,
	parameter int SIDE_W = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [LANES-1:0][VW-1:0]      radicand,
	input  logic [SIDE_W-1:0]             side_in,
	output logic                          out_valid,
	output logic [LANES-1:0][VW/2-1:0]    root,
	output logic [SIDE_W-1:0]             side_out
);
	localparam int RTW = VW / 2;

	logic                       valid_s [0:RTW];
	logic [LANES-1:0][RTW:0]    rem_s   [0:RTW];
	logic [LANES-1:0][VW-1:0]   rad_s   [0:RTW];
	logic [LANES-1:0][RTW-1:0]  root_s  [0:RTW];
	logic [SIDE_W-1:0]          side_s  [0:RTW];

	// feed the first stage
	assign valid_s[0] = in_valid;
	assign rem_s[0]   = '0;
	assign rad_s[0]   = radicand;
	assign root_s[0]  = '0;
	assign side_s[0]  = side_in;

	for (genvar k = 0; k < RTW; k++) begin : g_stage
		logic [LANES-1:0][RTW+2:0] trial;
		logic [LANES-1:0][RTW+2:0] cand;
		logic [LANES-1:0]          take;
		logic [LANES-1:0][RTW:0]   rem_nx;

		// bring down two radicand bits, try root*4+1
		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				trial[l]  = {rem_s[k][l], rad_s[k][l][VW-1:VW-2]};
				cand[l]   = {1'b0, root_s[k][l], 2'b01};
				take[l]   = trial[l] >= cand[l];
				rem_nx[l] = take[l] ? (RTW+1)'(trial[l] - cand[l]) : trial[l][RTW:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (en) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		// advance payload
		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < LANES; l++) begin
					rem_s[k+1][l]  <= rem_nx[l];
					rad_s[k+1][l]  <= {rad_s[k][l][VW-3:0], 2'b00};
					root_s[k+1][l] <= {root_s[k][l][RTW-2:0], take[l]};
				end
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = valid_s[RTW];
	assign root      = root_s[RTW];
	assign side_out  = side_s[RTW];
endmodule
`default_nettype wire

@@ tb/sv/two_proportion_z_statistic_checker.sv @@
// Checker: predicts each result of the z statistic block and compares it field by field.
`timescale 1ns / 1ps
module two_proportion_z_statistic_checker
	import tpz_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	tpz_in_if      samples,
	tpz_out_if     result,
	tpz_cfg_if     cfg,
	output int     fail_count,
	output int     pending
);
	localparam int F = FRAC_BITS_DEF;

	typedef struct packed {
		logic signed [EST_W-1:0] estimate;
		logic signed [Z_W-1:0]   z_score;
		logic [SE_W-1:0]         std_error;
		logic                    inputs_valid;
	} z_result_t;

	z_result_t                 expected_q[$];
	logic signed [DELTA_W-1:0] hyp_diff;

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned round_ratio(input longint unsigned n,
			input longint unsigned dd);
		return ((n << F) + dd / 2) / dd;
	endfunction

	function automatic z_result_t predict_z(input longint unsigned x1, input longint unsigned n1,
			input longint unsigned x2, input longint unsigned n2,
			input logic signed [DELTA_W-1:0] dp);
		z_result_t       r;
		longint unsigned one, p1, p2, pq, v, w, d, mag, q;
		longint          est, num;
		one = 64'd1 << F;
		r = '0;
		if (!(x1 < n1 && x2 < n2) || (x1 == 0 && x2 == 0)) return r;
		p1 = round_ratio(x1, n1);
		p2 = round_ratio(x2, n2);
		est = longint'(p1) - longint'(p2);
		v = (p1 * (one - p1)) / n1 + (p2 * (one - p2)) / n2;
		pq = round_ratio(x1 + x2, n1 + n2);
		if (pq < 1) pq = 1;
		if (pq > one - 1) pq = one - 1;
		w = (pq * (one - pq)) / n1 + (pq * (one - pq)) / n2;
		d = int_sqrt(w << SQ_SHIFT);
		num = est - longint'(dp);
		mag = (num < 0) ? longint'(-num) : longint'(num);
		if (mag == 0) q = 0;
		else if (d == 0) q = Z_MIN_MAG;
		else begin
			q = ((mag << (F + GUARD)) + d / 2) / d;
			if (q > Z_MIN_MAG) q = Z_MIN_MAG;
		end
		if (num >= 0 && q > Z_MAX) q = Z_MAX;
		r.estimate = est[EST_W-1:0];
		r.z_score = (num < 0) ? Z_W'(-q) : Z_W'(q);
		r.std_error = SE_W'(int_sqrt(v));
		r.inputs_valid = 1'b1;
		return r;
	endfunction

	assign pending = expected_q.size();

	// track the register, queue predictions, compare results
	always @(posedge clk or negedge arst_n) begin
		z_result_t e;
		if (!arst_n) begin
			hyp_diff <= '0;
			fail_count <= 0;
			expected_q.delete();
		end else begin
			if (cfg.valid && cfg.ready) hyp_diff <= cfg.data;
			if (samples.valid && samples.ready)
				expected_q.push_back(predict_z(samples.succ_a, samples.size_a,
					samples.succ_b, samples.size_b, hyp_diff));
			if (result.valid && result.ready) begin
				if (expected_q.size() == 0) begin
					$error("result transaction with no expectation");
					fail_count <= fail_count + 1;
				end else begin
					e = expected_q.pop_front();
					if (result.estimate !== e.estimate ||
							result.z_score !== e.z_score ||
							result.std_error !== e.std_error ||
							result.inputs_valid !== e.inputs_valid)
						fail_count <= fail_count + 1;
					if (result.estimate !== e.estimate)
						$error("estimate: expected %0d, got %0d", e.estimate, result.estimate);
					if (result.z_score !== e.z_score)
						$error("z_score: expected %0d, got %0d", e.z_score, result.z_score);
					if (result.std_error !== e.std_error)
						$error("std_error: expected %0d, got %0d", e.std_error,
							result.std_error);
					if (result.inputs_valid !== e.inputs_valid)
						$error("inputs_valid: expected %0d, got %0d", e.inputs_valid,
							result.inputs_valid);
				end
			end
		end
	end
endmodule

@@ tb/sv/two_proportion_z_statistic_test.sv @@
// Testbench top: drives samples, register writes and result stalls, gives the verdict.
`timescale 1ns / 1ps
module two_proportion_z_statistic_test;
	import tpz_pkg::*;

	localparam int LATENCY = 144;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;

	tpz_in_if  samples();
	tpz_out_if result();
	tpz_cfg_if cfg();

	two_proportion_z_statistic i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples.sink),
		.result (result.source),
		.cfg    (cfg.sink)
	);

	two_proportion_z_statistic_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples),
		.result    (result),
		.cfg       (cfg),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// write the hypothesised difference while the pipeline is empty
	task automatic write_delta(input logic signed [DELTA_W-1:0] value);
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
		cfg.valid <= 1'b1;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// send one sample transaction after a random gap
	task automatic send_sample(input logic [15:0] xa, input logic [15:0] na,
			input logic [15:0] xb, input logic [15:0] nb, input bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			samples.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		samples.valid <= 1'b1;
		samples.succ_a <= xa;
		samples.size_a <= na;
		samples.succ_b <= xb;
		samples.size_b <= nb;
		do @(posedge clk); while (!samples.ready);
		@(negedge clk);
	endtask

	// random sample: mostly valid, some invalid, sizes small in a minority, else full range
	task automatic send_random(input bit no_gap);
		logic [15:0] na, nb, xa, xb;
		int kind;
		kind = $urandom_range(0, 9);
		na = (kind < 4) ? 16'($urandom_range(1, 200)) : 16'($urandom);
		nb = (kind < 4) ? 16'($urandom_range(1, 200)) : 16'($urandom);
		if (na == 0) na = 1;
		if (nb == 0) nb = 1;
		xa = 16'($urandom_range(0, na - 1));
		xb = 16'($urandom_range(0, nb - 1));
		if (kind == 8) xa = 16'($urandom);
		if (kind == 9) begin
			xb = 16'($urandom);
			nb = 16'($urandom);
		end
		send_sample(xa, na, xb, nb, no_gap);
	endtask

	task automatic drain();
		samples.valid <= 1'b0;
	endtask

	// hold off each result transaction for a random number of cycles
	initial begin
		int stall;
		result.ready = 1'b0;
		forever begin
			@(negedge clk);
			stall = $urandom_range(0, 12);
			if (stall != 0) begin
				result.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result.ready <= 1'b1;
			do @(posedge clk); while (!result.valid);
		end
	end

	initial begin
		int deadline;
		samples.valid = 1'b0;
		samples.succ_a = '0;
		samples.size_a = '0;
		samples.succ_b = '0;
		samples.size_b = '0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: extremes and special cases at reset value
		send_sample(16'd1, 16'd2, 16'd0, 16'd3, 1'b0);
		send_sample(16'd0, 16'd5, 16'd0, 16'd5, 1'b0);
		send_sample(16'd5, 16'd5, 16'd1, 16'd4, 1'b0);
		send_sample(16'd1, 16'd4, 16'd9, 16'd4, 1'b0);
		send_sample(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
		send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		send_sample(16'hFFFE, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1);
		send_sample(16'h0001, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1);
		send_sample(16'hFFFE, 16'hFFFF, 16'hFFFE, 16'hFFFF, 1'b1);
		send_sample(16'd1, 16'd2, 16'd1, 16'd2, 1'b0);
		send_sample(16'd0, 16'd1, 16'd1, 16'd2, 1'b0);
		send_sample(16'h8000, 16'hFFFF, 16'h7FFF, 16'h8000, 1'b0);
		send_sample(16'd1, 16'hFFFF, 16'd1, 16'hFFFF, 1'b0);
		drain();

		// a difference of plus and minus one, then the extreme positive and negative register values
		write_delta(18'sd65536);
		send_sample(16'd1, 16'd2, 16'd1, 16'd2, 1'b0);
		send_sample(16'hFFFE, 16'hFFFF, 16'h0001, 16'hFFFF, 1'b0);
		send_sample(16'd1, 16'hFFFF, 16'hFFFE, 16'hFFFF, 1'b0);
		drain();
		write_delta(-18'sd65536);
		send_sample(16'd1, 16'hFFFF, 16'hFFFE, 16'hFFFF, 1'b0);
		send_sample(16'd3, 16'd7, 16'd2, 16'd9, 1'b0);
		drain();
		write_delta(18'sh1FFFF);
		send_sample(16'd3, 16'd7, 16'd2, 16'd9, 1'b0);
		drain();
		write_delta(18'sh20000);
		send_sample(16'd3, 16'd7, 16'd2, 16'd9, 1'b0);
		drain();

		// random phases under several settings
		for (int phase = 0; phase < 5; phase++) begin
			write_delta(phase == 4 ? 18'sd0 : 18'($urandom_range(0, 131071) - 65536));
			for (int k = 0; k < 100; k++) send_random(k >= 40 && k < 60);
			drain();
		end

		// wait for the pipeline to empty, then a little longer
		deadline = 0;
		while (pending != 0 && deadline < 100000) begin
			@(negedge clk);
			deadline++;
		end
		repeat (LATENCY + 20) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// hard stop on a hung pipeline
	initial begin
		#20ms;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
